>>> rtl/pba_pkg.sv
// shared types, constants and helpers for the pixel bytecode alu
// no dependencies; used by every rtl file of the block except pba_ram
`default_nettype none

package pba_pkg;

    localparam int NUM_REGS      = 4;
    localparam int CHANNEL_WIDTH = 16;
    localparam int IDX_W         = $clog2(NUM_REGS);
    localparam int FRAME_W       = 25;
    localparam int COUNT_W       = 24;
    localparam int MUL_SHIFT     = 8;

    localparam logic [7:0]         BYTE_MAX     = 8'hFF;
    localparam logic [7:0]         ALPHA_OPAQUE = 8'hFF;
    localparam logic [FRAME_W-1:0] COUNT_CAP    = FRAME_W'(1) << COUNT_W;
    localparam logic [FRAME_W-1:0] FRAME_RESET  = FRAME_W'(1);

    typedef enum logic [2:0] {
        OP_NOOP   = 3'd0,
        OP_MOVE   = 3'd1,
        OP_RETURN = 3'd2,
        OP_CONST  = 3'd3,
        OP_SAMPLE = 3'd4,
        OP_ADD    = 3'd5,
        OP_MUL    = 3'd6
    } op_t;

    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CHANNEL_WIDTH-1:0] chan_t;

    typedef struct packed {
        logic [2:0] operation;
        logic [1:0] dest_reg;
        logic [1:0] src_reg;
        logic [7:0] data_red;
        logic [7:0] data_green;
        logic [7:0] data_blue;
    } instr_t;

    typedef struct packed {
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
        logic [7:0] pixel_alpha;
        logic       last_pixel;
    } pixel_t;

    // register file read addresses presented with the request
    typedef struct packed {
        idx_t a;
        idx_t b;
    } rd_t;

    // execute stage control shared by the lanes
    typedef struct packed {
        logic       valid;
        logic [2:0] op;
        idx_t       dest;
        idx_t       src;
        idx_t       rda;
    } exe_t;

    function automatic idx_t reg_index(input logic [1:0] r);
        idx_t idx;
        if (int'(r) >= NUM_REGS)
        begin
            idx = IDX_W'(int'(r) - NUM_REGS);
        end
        else
        begin
            idx = IDX_W'(r);
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

>>> rtl/pba_ram.sv
// generic ram: one write port, two registered read ports
// no dependencies
`default_nettype none

module pba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

>>> rtl/pba_lane.sv
// one color lane: register file column, forwarding and channel alu
// depends on pba_pkg and pba_ram
`default_nettype none

module pba_lane (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire pba_pkg::rd_t  rd,
    input  wire pba_pkg::exe_t exe,
    input  wire logic [7:0]    data,
    output logic      [7:0]    pix_byte
);

    localparam int CW = pba_pkg::CHANNEL_WIDTH;

    logic [pba_pkg::NUM_REGS-1:0] vld_reg;
    logic [pba_pkg::NUM_REGS-1:0] vld_next;
    logic                         fwd_valid_reg;
    pba_pkg::idx_t                fwd_addr_reg;
    pba_pkg::chan_t               fwd_data_reg;

    pba_pkg::chan_t rdata_a;
    pba_pkg::chan_t rdata_b;
    pba_pkg::chan_t opa;
    pba_pkg::chan_t opb;
    pba_pkg::chan_t result;
    logic [CW:0]    sum;
    logic [2*CW-1:0] prod;
    logic [2*CW-1:0] prod_shr;
    logic           wr_en;
    logic           clear;

    pba_ram #(
        .WIDTH (CW),
        .DEPTH (pba_pkg::NUM_REGS)
    ) u_regs (
        .clk     (clk),
        .we      (wr_en),
        .waddr   (exe.dest),
        .wdata   (result),
        .raddr_a (rd.a),
        .raddr_b (rd.b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // operand select: just-written value, then stored value, zero if cleared
    always_comb
    begin
        if (fwd_valid_reg && fwd_addr_reg == exe.rda)
        begin
            opa = fwd_data_reg;
        end
        else
        begin
            opa = vld_reg[exe.rda] ? rdata_a : '0;
        end
        if (fwd_valid_reg && fwd_addr_reg == exe.src)
        begin
            opb = fwd_data_reg;
        end
        else
        begin
            opb = vld_reg[exe.src] ? rdata_b : '0;
        end
    end

    assign sum      = {1'b0, opa} + {1'b0, opb};
    assign prod     = (2*CW)'(opa) * (2*CW)'(opb);
    assign prod_shr = prod >> pba_pkg::MUL_SHIFT;

    always_comb
    begin
        result = '0;
        wr_en  = 1'b0;
        clear  = 1'b0;
        unique case (exe.op)
            pba_pkg::OP_MOVE:
            begin
                result = opb;
                wr_en  = exe.valid;
            end
            pba_pkg::OP_CONST, pba_pkg::OP_SAMPLE:
            begin
                result = CW'(data);
                wr_en  = exe.valid;
            end
            pba_pkg::OP_ADD:
            begin
                result = sum[CW] ? '1 : sum[CW-1:0];
                wr_en  = exe.valid;
            end
            pba_pkg::OP_MUL:
            begin
                result = (|prod_shr[2*CW-1:CW]) ? '1 : prod_shr[CW-1:0];
                wr_en  = exe.valid;
            end
            pba_pkg::OP_RETURN:
            begin
                clear = exe.valid;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (clear)
        begin
            vld_next = '0;
        end
        else if (wr_en)
        begin
            vld_next[exe.dest] = 1'b1;
        end
    end

    assign pix_byte = (|opa[CW-1:8]) ? pba_pkg::BYTE_MAX : opa[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg       <= vld_next;
            fwd_valid_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_addr_reg <= exe.dest;
        fwd_data_reg <= result;
    end

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> (vld_reg == '0) && !fwd_valid_reg)
        else $error("register file not emptied after return");

    a_write_marks: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> vld_reg[$past(exe.dest)])
        else $error("written register not marked valid");

    a_write_forwards: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> fwd_valid_reg && fwd_addr_reg == $past(exe.dest)
            && fwd_data_reg == $past(result))
        else $error("forward path does not hold the last write");

endmodule

`default_nettype wire

>>> rtl/pba_merge.sv
// merge stage: assembles the lane bytes into a pixel, frame counter, output buffer
// depends on pba_pkg
`default_nettype none

module pba_merge (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_write,
    input  wire logic [pba_pkg::FRAME_W-1:0]  cfg_data,
    input  wire logic                         ret,
    input  wire logic [7:0]                   red,
    input  wire logic [7:0]                   green,
    input  wire logic [7:0]                   blue,
    output logic                              hold,
    output pba_pkg::pixel_t                   pixel,
    output logic                              pixel_valid,
    input  wire logic                         pixel_stall
);

    logic [pba_pkg::FRAME_W-1:0] frame_reg;
    logic [pba_pkg::COUNT_W-1:0] count_reg;
    logic [pba_pkg::COUNT_W-1:0] count_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        skid_valid_reg;
    logic                        skid_valid_next;
    pba_pkg::pixel_t             out_reg;
    pba_pkg::pixel_t             skid_reg;
    pba_pkg::pixel_t             new_pix;

    logic [pba_pkg::FRAME_W-1:0] total;
    logic [pba_pkg::FRAME_W-1:0] count_inc;
    logic                        last;
    logic                        pop;
    logic                        load_new;
    logic                        load_skid;
    logic                        park_new;
    logic [1:0]                  occ;

    always_comb
    begin
        priority if (frame_reg == '0)
        begin
            total = pba_pkg::FRAME_W'(1);
        end
        else if (frame_reg > pba_pkg::COUNT_CAP)
        begin
            total = pba_pkg::COUNT_CAP;
        end
        else
        begin
            total = frame_reg;
        end
    end

    assign count_inc = {1'b0, count_reg} + pba_pkg::FRAME_W'(1);
    assign last      = count_inc >= total;
    assign count_next = last ? '0 : count_inc[pba_pkg::COUNT_W-1:0];

    assign new_pix = '{pixel_red:   red,
                       pixel_green: green,
                       pixel_blue:  blue,
                       pixel_alpha: pba_pkg::ALPHA_OPAQUE,
                       last_pixel:  last};

    // a request is taken only while buffer plus in-flight returns, less this cycle's pop,
    // leave a slot
    assign pop  = out_valid_reg && !pixel_stall;
    assign occ  = 2'(out_valid_reg) + 2'(skid_valid_reg) + 2'(ret) - 2'(pop);
    assign hold = occ >= 2'd2;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_new        = 1'b0;
        load_skid       = 1'b0;
        park_new        = 1'b0;
        priority if (skid_valid_reg)
        begin
            if (pop)
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (ret)
        begin
            if (!out_valid_reg || pop)
            begin
                load_new       = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                park_new        = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg      <= pba_pkg::FRAME_RESET;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                frame_reg <= cfg_data;
            end
            if (ret)
            begin
                count_reg <= count_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_new)
        begin
            out_reg <= new_pix;
        end
        else if (load_skid)
        begin
            out_reg <= skid_reg;
        end
        if (park_new)
        begin
            skid_reg <= new_pix;
        end
    end

    assign pixel       = out_reg;
    assign pixel_valid = out_valid_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

endmodule

`default_nettype wire

>>> rtl/pixel_bytecode_alu.sv
// pixel bytecode alu top level: request decode, three color lanes, merge stage
// depends on pba_pkg, pba_lane, pba_merge (pba_ram through the lanes)
//
// usage:
//   instr / instr_valid / instr_stall carry one decoded instruction per
//   request; a request is taken on a clock edge with instr_valid high and
//   instr_stall low. pixel / pixel_valid / pixel_stall carry one result per
//   return instruction, in order. cfg_write loads frame_pixels from cfg_data.
//   throughput is one instruction per cycle while instr_stall is low, set by the
//   read-compute-write loop of each lane's register file (forwarded write).
//   a return's pixel passes the request register and then the merge stage's
//   output register, waiting in the skid entry while the output register is held.
//   while the receiver stalls, the output register and one skid entry hold
//   up to two pixels; instr_stall rises when the held pixels plus a return
//   in flight, less one taken in the same cycle, fill both slots.
//   reset (rst_n low, asynchronous) empties all registers via valid bits,
//   zeroes the pixel counter and sets frame_pixels to one; no clearing pass.
`default_nettype none

module pixel_bytecode_alu (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire pba_pkg::instr_t             instr,
    input  wire logic                        instr_valid,
    output logic                             instr_stall,
    output pba_pkg::pixel_t                  pixel,
    output logic                             pixel_valid,
    input  wire logic                        pixel_stall,
    input  wire logic                        cfg_write,
    input  wire logic [pba_pkg::FRAME_W-1:0] cfg_data
);

    logic            accept;
    logic            hold;
    logic            s1_valid_reg;
    pba_pkg::instr_t s1_instr_reg;
    pba_pkg::rd_t    rd;
    pba_pkg::exe_t   exe;
    logic            ret;
    logic [7:0]      red_byte;
    logic [7:0]      green_byte;
    logic [7:0]      blue_byte;

    assign instr_stall = hold;
    assign accept      = instr_valid && !hold;

    // return reads register 0 on the a port
    assign rd.a = (instr.operation == pba_pkg::OP_RETURN) ? '0
                                                         : pba_pkg::reg_index(instr.dest_reg);
    assign rd.b = pba_pkg::reg_index(instr.src_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_instr_reg <= instr;
        end
    end

    assign exe.valid = s1_valid_reg;
    assign exe.op    = s1_instr_reg.operation;
    assign exe.dest  = pba_pkg::reg_index(s1_instr_reg.dest_reg);
    assign exe.src   = pba_pkg::reg_index(s1_instr_reg.src_reg);
    assign exe.rda   = (s1_instr_reg.operation == pba_pkg::OP_RETURN) ? '0 : exe.dest;

    assign ret = s1_valid_reg && (s1_instr_reg.operation == pba_pkg::OP_RETURN);

    pba_lane u_lane_red (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd       (rd),
        .exe      (exe),
        .data     (s1_instr_reg.data_red),
        .pix_byte (red_byte)
    );

    pba_lane u_lane_green (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd       (rd),
        .exe      (exe),
        .data     (s1_instr_reg.data_green),
        .pix_byte (green_byte)
    );

    pba_lane u_lane_blue (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd       (rd),
        .exe      (exe),
        .data     (s1_instr_reg.data_blue),
        .pix_byte (blue_byte)
    );

    pba_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .ret         (ret),
        .red         (red_byte),
        .green       (green_byte),
        .blue        (blue_byte),
        .hold        (hold),
        .pixel       (pixel),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall)
    );

endmodule

`default_nettype wire
